@@ sv/dtt_pkg.sv @@
package dtt_pkg;

	localparam int DIFF_W              = 64;
	localparam int WORD_W              = 64;
	localparam int TARGET_W            = 256;
	localparam int SCALE_SHIFT_DEFAULT = 32;

	// Control that travels with an item down the cell row
	typedef struct packed {
		logic valid;
		logic zero;    // difficulty was zero: target is all ones
	} stage_ctl_t;

endpackage

@@ sv/difficulty_to_target_divider.sv @@
// Share difficulty to 256-bit target.
//
// Input channel: difficulty (64 bits) on in_valid / in_ready. Output channel:
// the target floor((2^256-1) / (difficulty * 2^SCALE_SHIFT)) as four 64-bit
// words, most significant first, on out_valid / out_ready. A zero difficulty
// gives all ones.
//
// The quotient comes from a row of 256-SCALE_SHIFT restoring-division cells,
// one quotient bit each, every cell a 65-bit compare/subtract and a register.
// The top SCALE_SHIFT quotient bits are always zero and get no cell.
// Throughput: one item per cycle while the output buffer is not full. An
// accepted item is registered in the first cell, moves one cell on each
// time the row advances, and goes from the last cell into the output buffer.
//
// A two-entry output buffer (output register plus skid slot) sits after the
// last cell. The cell row advances while that buffer is not full, so the row
// keeps moving while one result waits; once both slots hold results, in_ready
// drops and the row holds. Reset clears all valid bits and the buffer count;
// items in flight are dropped.
module difficulty_to_target_divider #(
	parameter int SCALE_SHIFT = dtt_pkg::SCALE_SHIFT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dtt_pkg::DIFF_W-1:0]    difficulty,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dtt_pkg::WORD_W-1:0]    target_word_top,
	output logic [dtt_pkg::WORD_W-1:0]    target_word_upper,
	output logic [dtt_pkg::WORD_W-1:0]    target_word_lower,
	output logic [dtt_pkg::WORD_W-1:0]    target_word_bottom
);
	import dtt_pkg::*;

	localparam int NUM_BITS = TARGET_W - SCALE_SHIFT;

	logic                 en;
	logic                 buf_full;
	stage_ctl_t           in_ctl;
	stage_ctl_t           ctl_s   [NUM_BITS];
	logic [DIFF_W-1:0]    rem_s   [NUM_BITS];
	logic [DIFF_W-1:0]    dvs_s   [NUM_BITS];
	logic [NUM_BITS-1:0]  quot_s  [NUM_BITS];
	logic [TARGET_W-1:0]  target_d;
	logic [TARGET_W-1:0]  target_q;

	// Advance the whole row whenever the output buffer has room
	assign en       = ~buf_full;
	assign in_ready = en;

	assign in_ctl.valid = in_valid & en;
	assign in_ctl.zero  = (difficulty == '0);

	genvar k;
	generate
		for (k = 0; k < NUM_BITS; k++) begin : g_cell
			if (k == 0) begin : g_first
				dtt_cell #(.QW(NUM_BITS)) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.en        (en),
					.prev_ctl  (in_ctl),
					.prev_rem  ({DIFF_W{1'b0}}),
					.prev_dvs  (difficulty),
					.prev_quot ({NUM_BITS{1'b0}}),
					.next_ctl  (ctl_s[k]),
					.next_rem  (rem_s[k]),
					.next_dvs  (dvs_s[k]),
					.next_quot (quot_s[k])
				);
			end else begin : g_rest
				dtt_cell #(.QW(NUM_BITS)) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.en        (en),
					.prev_ctl  (ctl_s[k-1]),
					.prev_rem  (rem_s[k-1]),
					.prev_dvs  (dvs_s[k-1]),
					.prev_quot (quot_s[k-1]),
					.next_ctl  (ctl_s[k]),
					.next_rem  (rem_s[k]),
					.next_dvs  (dvs_s[k]),
					.next_quot (quot_s[k])
				);
			end
		end
	endgenerate

	// Zero-extend the quotient; a zero difficulty forces all ones
	assign target_d = ctl_s[NUM_BITS-1].zero ? {TARGET_W{1'b1}}
	                                         : TARGET_W'(quot_s[NUM_BITS-1]);

	dtt_out_buf #(.W(TARGET_W)) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ctl_s[NUM_BITS-1].valid & en),
		.push_data (target_d),
		.full      (buf_full),
		.pop_valid (out_valid),
		.pop_ready (out_ready),
		.pop_data  (target_q)
	);

	assign target_word_top    = target_q[4*WORD_W-1:3*WORD_W];
	assign target_word_upper  = target_q[3*WORD_W-1:2*WORD_W];
	assign target_word_lower  = target_q[2*WORD_W-1:WORD_W];
	assign target_word_bottom = target_q[WORD_W-1:0];

endmodule

@@ sv/dtt_cell.sv @@
module dtt_cell #(
	parameter int QW = 224
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  dtt_pkg::stage_ctl_t           prev_ctl,
	input  logic [dtt_pkg::DIFF_W-1:0]    prev_rem,
	input  logic [dtt_pkg::DIFF_W-1:0]    prev_dvs,
	input  logic [QW-1:0]                 prev_quot,
	output dtt_pkg::stage_ctl_t           next_ctl,
	output logic [dtt_pkg::DIFF_W-1:0]    next_rem,
	output logic [dtt_pkg::DIFF_W-1:0]    next_dvs,
	output logic [QW-1:0]                 next_quot
);
	import dtt_pkg::*;

	logic [DIFF_W:0]     shifted;
	logic [DIFF_W+1:0]   diff;
	logic                qbit;
	logic [DIFF_W-1:0]   rem_d;
	stage_ctl_t          ctl_s1;
	logic [DIFF_W-1:0]   rem_s1;
	logic [DIFF_W-1:0]   dvs_s1;
	logic [QW-1:0]       quot_s1;

	// Bring down a one bit of the numerator, then try the subtract
	assign shifted = {prev_rem, 1'b1};
	assign diff    = {1'b0, shifted} - {2'b00, prev_dvs};
	assign qbit    = ~diff[DIFF_W+1];
	assign rem_d   = qbit ? diff[DIFF_W-1:0] : shifted[DIFF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= prev_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_d;
			dvs_s1  <= prev_dvs;
			quot_s1 <= {prev_quot[QW-2:0], qbit};
		end
	end

	assign next_ctl  = ctl_s1;
	assign next_rem  = rem_s1;
	assign next_dvs  = dvs_s1;
	assign next_quot = quot_s1;

endmodule

@@ sv/dtt_out_buf.sv @@
module dtt_out_buf #(
	parameter int W = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam logic [1:0] CNT_EMPTY = 2'd0;
	localparam logic [1:0] CNT_FULL  = 2'd2;

	logic [1:0]   count_q;
	logic [W-1:0] head_q;
	logic [W-1:0] skid_q;
	logic         pop;

	assign pop       = pop_valid & pop_ready;
	assign pop_valid = (count_q != CNT_EMPTY);
	assign full      = (count_q == CNT_FULL);
	assign pop_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_EMPTY;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			// only reachable with one entry: replace the head
			head_q <= push_data;
		end else if (push) begin
			if (count_q == CNT_EMPTY) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (pop && count_q == CNT_FULL) begin
			head_q <= skid_q;
		end
	end

endmodule

@@ tb/tb_difficulty_to_target_divider.sv @@
`timescale 1ns / 1ps

module tb_difficulty_to_target_divider;
	import dtt_pkg::*;

	// Quotient bits of the numerator that are ones: 2^(256-shift) - 1
	localparam int SCALE_SHIFT  = SCALE_SHIFT_DEFAULT;
	localparam int NUM_ONES     = TARGET_W - SCALE_SHIFT;
	// Equal to the number of cells in the row
	localparam int LATENCY      = TARGET_W - SCALE_SHIFT;
	localparam int RANDOM_ITEMS = 680;
	localparam int STALL_LIMIT  = 4000;
	localparam int MAX_REPORTS  = 10;

	// Idle phases: sender idles lightly first, then heavily, then neither
	typedef enum int {
		PH_SEND_LIGHT,
		PH_SEND_HEAVY,
		PH_NO_IDLE
	} idle_phase_t;

	typedef struct packed {
		logic [WORD_W-1:0] top;
		logic [WORD_W-1:0] upper;
		logic [WORD_W-1:0] lower;
		logic [WORD_W-1:0] bottom;
	} target_t;

	typedef struct {
		logic [DIFF_W-1:0] difficulty;
		idle_phase_t       phase;
		bit                drain_first;   // hold until every target is out
	} diff_item_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [DIFF_W-1:0]   difficulty;
	logic                out_valid;
	logic                out_ready;
	logic [WORD_W-1:0]   target_word_top;
	logic [WORD_W-1:0]   target_word_upper;
	logic [WORD_W-1:0]   target_word_lower;
	logic [WORD_W-1:0]   target_word_bottom;

	diff_item_t   pending_diffs[$];
	target_t      expected_targets[$];
	idle_phase_t  cur_phase;
	bit           in_took;
	int           error_count;
	int           quiet_cycles;

	difficulty_to_target_divider #(
		.SCALE_SHIFT(SCALE_SHIFT)
	) u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.difficulty        (difficulty),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.target_word_top   (target_word_top),
		.target_word_upper (target_word_upper),
		.target_word_lower (target_word_lower),
		.target_word_bottom(target_word_bottom)
	);

	// Restoring long division of (2^NUM_ONES - 1) by the difficulty, one
	// quotient bit per step, MSB first. The remainder carries a 65th bit so
	// that a shift never loses the top bit.
	function automatic target_t compute_target(input logic [DIFF_W-1:0] d);
		logic [TARGET_W-1:0] quo;
		logic [DIFF_W:0]     rem;
		target_t             res;
		quo = '0;
		rem = '0;
		if (d == '0) begin
			quo = '1;
		end else begin
			for (int i = TARGET_W - 1; i >= 0; i--) begin
				rem = {rem[DIFF_W-1:0], (i < NUM_ONES) ? 1'b1 : 1'b0};
				if (rem >= {1'b0, d}) begin
					rem    = rem - {1'b0, d};
					quo[i] = 1'b1;
				end
			end
		end
		res.top    = quo[255:192];
		res.upper  = quo[191:128];
		res.lower  = quo[127:64];
		res.bottom = quo[63:0];
		return res;
	endfunction

	function automatic int send_idle_pct(input idle_phase_t ph);
		case (ph)
			PH_SEND_LIGHT: return 20;
			PH_SEND_HEAVY: return 48;
			default:       return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct(input idle_phase_t ph);
		case (ph)
			PH_SEND_LIGHT: return 48;
			PH_SEND_HEAVY: return 20;
			default:       return 0;
		endcase
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("%s", msg);
		end
	endtask

	// Free-running clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Driver: change inputs at the falling edge. Drop valid only once the
	// item was taken at the preceding rising edge, so valid never waits on
	// ready and the payload holds while the item is pending.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_took) begin
				if (pending_diffs.size() > 0 &&
				    !(pending_diffs[0].drain_first && expected_targets.size() > 0) &&
				    $urandom_range(99) >= send_idle_pct(pending_diffs[0].phase)) begin
					cur_phase  <= pending_diffs[0].phase;
					difficulty <= pending_diffs[0].difficulty;
					in_valid   <= 1'b1;
					void'(pending_diffs.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
			// Receiver stalls follow the phase of the latest item sent
			out_ready <= ($urandom_range(99) >= recv_idle_pct(cur_phase));
		end
	end

	// Monitor: sample both channels at the rising edge. Record the predicted
	// target of each accepted item, and check each result against the oldest.
	always @(posedge clk) begin
		target_t want;
		in_took <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_targets.push_back(compute_target(difficulty));
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_targets.size() == 0) begin
				flag_error($sformatf("unexpected target %h_%h_%h_%h",
				                     target_word_top, target_word_upper,
				                     target_word_lower, target_word_bottom));
			end else begin
				want = expected_targets.pop_front();
				if (target_word_top !== want.top)
					flag_error($sformatf("target_word_top: expected %h, got %h",
					                     want.top, target_word_top));
				if (target_word_upper !== want.upper)
					flag_error($sformatf("target_word_upper: expected %h, got %h",
					                     want.upper, target_word_upper));
				if (target_word_lower !== want.lower)
					flag_error($sformatf("target_word_lower: expected %h, got %h",
					                     want.lower, target_word_lower));
				if (target_word_bottom !== want.bottom)
					flag_error($sformatf("target_word_bottom: expected %h, got %h",
					                     want.bottom, target_word_bottom));
			end
		end
	end

	// Watchdog: end the run when neither channel moves an item for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [DIFF_W-1:0] dirs[$];
		logic [DIFF_W-1:0] val;
		diff_item_t        item;
		int                sh;

		// Hold every input at a known value from time zero
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_ready    = 1'b0;
		difficulty   = '0;
		cur_phase    = PH_SEND_LIGHT;
		in_took      = 1'b0;
		error_count  = 0;
		quiet_cycles = 0;

		// Directed: zero (all-ones target), smallest divisors, values where the difficulty
		// first needs its upper half, the top of the range and alternating bit patterns
		dirs = {64'd0, 64'd1, 64'd2, 64'd3, 64'd7, 64'd10, 64'd1000,
		        64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
		        64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
		        64'h0000_0001_0000_0001, 64'h0000_FFFF_FFFF_FFFF,
		        64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
		        64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000,
		        64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
		        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
		foreach (dirs[i]) begin
			item.difficulty  = dirs[i];
			item.phase       = PH_SEND_LIGHT;
			item.drain_first = 1'b0;
			pending_diffs.push_back(item);
		end

		// Random: full-width values, values of random bit length so small divisors
		// get their share, complements of those, powers of two and neighbors, zero
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			val = {$urandom, $urandom};
			sh  = $urandom_range(63);
			case ($urandom_range(9))
				0, 1, 2, 3: ;
				4, 5, 6:    val = val >> sh;
				7:          val = (64'd1 << sh) + 64'($urandom_range(2)) - 64'd1;
				8:          val = ~(val >> sh);
				default:    val = ($urandom_range(3) == 0) ? '0 : val;
			endcase
			item.difficulty  = val;
			item.phase       = (n < RANDOM_ITEMS / 3)     ? PH_SEND_LIGHT :
			                   (n < 2 * RANDOM_ITEMS / 3) ? PH_SEND_HEAVY : PH_NO_IDLE;
			// Pause once mid-run until every target is out
			item.drain_first = (n == RANDOM_ITEMS / 2);
			pending_diffs.push_back(item);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last item to go in, then for every target to come out
		while (pending_diffs.size() != 0 || in_valid) @(negedge clk);
		while (expected_targets.size() != 0) @(negedge clk);
		// Run on past the last result to catch any spurious one
		repeat (LATENCY + 16) @(negedge clk);

		if (error_count == 0 && expected_targets.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/dtt_pkg.sv
sv/dtt_cell.sv
sv/dtt_out_buf.sv
sv/difficulty_to_target_divider.sv
tb/tb_difficulty_to_target_divider.sv
